>>> design/rgb_palette_indexer_top_assert.svh
// ----------------------------------------------------------------------------
// RGB palette indexer assertion macros
// Shared macros for the concurrent assertions of the palette indexer.
// ----------------------------------------------------------------------------
`ifndef RGB_PALETTE_INDEXER_TOP_ASSERT_SVH
`define RGB_PALETTE_INDEXER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPI_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/rpi_pkg.sv
// ----------------------------------------------------------------------------
// RGB palette indexer package
// Field widths, register indexes and the controller to datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package rpi_pkg;

   localparam int RGB_W     = 24;
   localparam int INDEX_W   = 8;
   localparam int COUNT_W   = 9;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRANS_ENABLE = 1'b0,
      CSR_TRANS_COLOUR = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } rpi_cmd_type;

   typedef struct packed {
      logic scan_done;
   } rpi_status_type;

endpackage

`default_nettype wire

>>> design/rpi_ctrl.sv
// ----------------------------------------------------------------------------
// RGB palette indexer controller
// Sequences the load, palette scan and result phases of each item.
// ----------------------------------------------------------------------------
`default_nettype none

module rpi_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   output rpi_pkg::rpi_cmd_type         cmd,
   input  wire rpi_pkg::rpi_status_type status
);
   import rpi_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type state_ff;
   logic      busy_ff;

   always_comb begin
      cmd.load   = (state_ff == ST_IDLE) && start;
      cmd.scan   = (state_ff == ST_SCAN);
      cmd.finish = (state_ff == ST_SCAN) && status.scan_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_SCAN;
                  busy_ff  <= 1'b1;
               end
            end
            ST_SCAN: begin
               if (status.scan_done) begin
                  state_ff <= ST_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

>>> design/rpi_datapath.sv
// ----------------------------------------------------------------------------
// RGB palette indexer datapath
// Palette memory, scan address, match tracking, registers and result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rpi_datapath #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire rpi_pkg::rpi_cmd_type            cmd,
   output rpi_pkg::rpi_status_type              status,
   input  wire logic [rpi_pkg::RGB_W-1:0]       req_pixel_rgb,
   input  wire logic                            req_first_pixel,
   input  wire logic                            req_last_pixel,
   input  wire logic                            csr_write_enable,
   input  wire logic [rpi_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [rpi_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output logic                                 rsp_valid,
   output logic [rpi_pkg::INDEX_W-1:0]          rsp_pixel_index,
   output logic                                 rsp_is_new_colour,
   output logic [rpi_pkg::COUNT_W-1:0]          rsp_colour_count,
   output logic                                 rsp_too_many_colours,
   output logic                                 rsp_trans_found,
   output logic [rpi_pkg::INDEX_W-1:0]          rsp_trans_index,
   output logic                                 rsp_end_of_image
);
   import rpi_pkg::*;

   localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(PALETTE_ENTRIES);

   logic [RGB_W-1:0] palette_mem [PALETTE_ENTRIES];

   logic [RGB_W-1:0] pix_ff;
   logic             last_ff;
   logic [CNT_W-1:0] used_ff, used_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] addr_ff, addr_in;
   logic [RGB_W-1:0] rd_data_ff;
   logic             rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic             thit_ff, thit_in;
   logic [IDX_W-1:0] tidx_ff, tidx_in;
   logic             trans_en_ff;
   logic [RGB_W-1:0] trans_col_ff;
   logic             rsp_valid_ff;

   logic             issue;
   logic             add;
   logic             ovf_new;
   logic [IDX_W-1:0] res_idx;
   logic             res_tfound;
   logic [IDX_W-1:0] res_tidx;

   assign issue = cmd.scan && (addr_ff < used_ff) && !ovf_ff;
   assign status.scan_done = !issue && !rd_valid_ff;

   // Result of the completed scan.
   always_comb begin
      add     = !ovf_ff && !hit_ff && (used_ff < FULL);
      ovf_new = ovf_ff || (!hit_ff && !(used_ff < FULL));
      if (ovf_ff) begin
         res_idx = '0;
      end else if (hit_ff) begin
         res_idx = hit_idx_ff;
      end else if (add) begin
         res_idx = used_ff[IDX_W-1:0];
      end else begin
         res_idx = '0;
      end
      res_tfound = last_ff && trans_en_ff && !ovf_new &&
                   (thit_ff || (add && (pix_ff == trans_col_ff)));
      res_tidx   = thit_ff ? tidx_ff : used_ff[IDX_W-1:0];
   end

   always_comb begin
      used_in     = used_ff;
      ovf_in      = ovf_ff;
      addr_in     = addr_ff;
      rd_valid_in = issue;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      thit_in     = thit_ff;
      tidx_in     = tidx_ff;
      if (cmd.load) begin
         if (req_first_pixel) begin
            used_in = '0;
            ovf_in  = 1'b0;
         end
         addr_in     = '0;
         rd_valid_in = 1'b0;
         hit_in      = 1'b0;
         thit_in     = 1'b0;
      end else begin
         if (issue) begin
            addr_in = addr_ff + 1'b1;
         end
         if (rd_valid_ff && !hit_ff && (rd_data_ff == pix_ff)) begin
            hit_in     = 1'b1;
            hit_idx_in = rd_idx_ff;
         end
         if (rd_valid_ff && !thit_ff && (rd_data_ff == trans_col_ff)) begin
            thit_in = 1'b1;
            tidx_in = rd_idx_ff;
         end
         if (cmd.finish) begin
            used_in = used_ff + CNT_W'(add);
            ovf_in  = ovf_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= palette_mem[addr_ff[IDX_W-1:0]];
      end
      if (cmd.finish && add) begin
         palette_mem[used_ff[IDX_W-1:0]] <= pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         ovf_ff       <= 1'b0;
         rd_valid_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         thit_ff      <= 1'b0;
         addr_ff      <= '0;
         trans_en_ff  <= 1'b0;
         trans_col_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         ovf_ff       <= ovf_in;
         rd_valid_ff  <= rd_valid_in;
         hit_ff       <= hit_in;
         thit_ff      <= thit_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= cmd.finish;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_TRANS_ENABLE: trans_en_ff  <= csr_write_data[0];
               CSR_TRANS_COLOUR: trans_col_ff <= csr_write_data[RGB_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_idx_ff <= hit_idx_in;
      tidx_ff    <= tidx_in;
      rd_idx_ff  <= addr_ff[IDX_W-1:0];
      if (cmd.load) begin
         pix_ff  <= req_pixel_rgb;
         last_ff <= req_last_pixel;
      end
      if (cmd.finish) begin
         rsp_pixel_index      <= INDEX_W'(res_idx);
         rsp_is_new_colour    <= add;
         rsp_colour_count     <= COUNT_W'(used_in);
         rsp_too_many_colours <= ovf_new;
         rsp_trans_found      <= res_tfound;
         rsp_trans_index      <= res_tfound ? INDEX_W'(res_tidx) : '0;
         rsp_end_of_image     <= last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> design/rgb_palette_indexer_top.sv
// ----------------------------------------------------------------------------
// RGB palette indexer top level
// Maps a stream of 24-bit RGB pixels to indexes in a palette built on the fly.
// ----------------------------------------------------------------------------
// A pixel item is taken when start is high while busy is low. The block then
// scans the palette memory one entry per cycle through its single read port,
// comparing each entry with both the pixel and the transparent colour. The read
// data is registered, so the last comparison lands in the cycle after the last
// read. With entries_used colours in the palette when the item is taken (after
// any clearing by first_pixel), the scan reads entries_used entries, at most
// PALETTE_ENTRIES, and the result is registered once the last comparison is
// done. An empty palette, or one that has overflowed, needs no scan: busy is
// high for one cycle. busy falls in the cycle of the strobe, so the next item
// can be taken then. The result is shown for one cycle with rsp_valid high and
// cannot be held off, so the receiver must take it in that cycle. Configuration
// writes are taken at any time but belong in periods when busy is low. The
// palette memory needs no clearing pass after reset.
`default_nettype none

module rgb_palette_indexer_top #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [rpi_pkg::RGB_W-1:0]       req_pixel_rgb,
   input  wire logic                            req_first_pixel,
   input  wire logic                            req_last_pixel,
   input  wire logic                            csr_write_enable,
   input  wire logic [rpi_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [rpi_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output logic                                 rsp_valid,
   output logic [rpi_pkg::INDEX_W-1:0]          rsp_pixel_index,
   output logic                                 rsp_is_new_colour,
   output logic [rpi_pkg::COUNT_W-1:0]          rsp_colour_count,
   output logic                                 rsp_too_many_colours,
   output logic                                 rsp_trans_found,
   output logic [rpi_pkg::INDEX_W-1:0]          rsp_trans_index,
   output logic                                 rsp_end_of_image
);
   import rpi_pkg::*;

   rpi_cmd_type    cmd;
   rpi_status_type status;

   rpi_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   rpi_datapath #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_pixel_rgb        (req_pixel_rgb),
      .req_first_pixel      (req_first_pixel),
      .req_last_pixel       (req_last_pixel),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .rsp_valid            (rsp_valid),
      .rsp_pixel_index      (rsp_pixel_index),
      .rsp_is_new_colour    (rsp_is_new_colour),
      .rsp_colour_count     (rsp_colour_count),
      .rsp_too_many_colours (rsp_too_many_colours),
      .rsp_trans_found      (rsp_trans_found),
      .rsp_trans_index      (rsp_trans_index),
      .rsp_end_of_image     (rsp_end_of_image)
   );

endmodule

`default_nettype wire

>>> design/rpi_checker.sv
// ----------------------------------------------------------------------------
// RGB palette indexer checker
// Port-level assertions on the handshake and result fields, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_palette_indexer_top_assert.svh"

module rpi_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           start,
   input wire logic                           busy,
   input wire logic                           rsp_valid,
   input wire logic [rpi_pkg::INDEX_W-1:0]    rsp_pixel_index,
   input wire logic                           rsp_is_new_colour,
   input wire logic [rpi_pkg::COUNT_W-1:0]    rsp_colour_count,
   input wire logic                           rsp_too_many_colours,
   input wire logic                           rsp_trans_found,
   input wire logic                           rsp_end_of_image
);
   import rpi_pkg::*;

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(256);

   `RPI_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy not raised after an item was taken")
   `RPI_ASSERT_SAME(a_result_idle, clock, reset, rsp_valid, !busy, "result shown while still busy")
   `RPI_ASSERT_SAME(a_count_range, clock, reset, rsp_valid, rsp_colour_count <= MAX_COUNT, "colour count out of range")
   `RPI_ASSERT_SAME(a_overflow_fields, clock, reset, rsp_valid && rsp_too_many_colours, (rsp_pixel_index == '0) && !rsp_is_new_colour && !rsp_trans_found, "overflowed item carries an index")
   `RPI_ASSERT_SAME(a_trans_last_only, clock, reset, rsp_valid && !rsp_end_of_image, !rsp_trans_found, "transparent colour reported before the last item")

endmodule

bind rgb_palette_indexer_top rpi_checker u_rpi_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .rsp_valid            (rsp_valid),
   .rsp_pixel_index      (rsp_pixel_index),
   .rsp_is_new_colour    (rsp_is_new_colour),
   .rsp_colour_count     (rsp_colour_count),
   .rsp_too_many_colours (rsp_too_many_colours),
   .rsp_trans_found      (rsp_trans_found),
   .rsp_end_of_image     (rsp_end_of_image)
);

`default_nettype wire
